// File: hdl/pqhm_pkg.sv
// pqhm_pkg: shared types and constants of the proximity query hit marker
// token and hit entry layouts, register codes, configuration and result words
// no dependencies
package pqhm_pkg;

    localparam int TERM_KEYS = 32;
    localparam int SEEN_CNT_W = $clog2(TERM_KEYS + 1);
    localparam int APB_ADDR_W = 5;
    localparam logic [15:0] HIT_MAX = 16'hFFFF;

    typedef struct packed {
        logic        rep;
        logic [7:0]  seq;
        logic        sv;
        logic [4:0]  term;
        logic [19:0] pos;
        logic [15:0] sub;
        logic [15:0] ctx;
    } tok_t;

    typedef struct packed {
        logic       op;
        logic       last;
        tok_t       tok;
        logic [9:0] read_index;
    } item_t;

    typedef struct packed {
        logic [4:0]  terms_needed;
        logic [19:0] window_size;
        logic        reuse_mode;
        logic        directed;
        logic        use_subcontext;
        logic        use_sequences;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] hit_id;
    } res_t;

    typedef struct packed {
        logic        mark;
        logic [15:0] hit;
    } hit_ent_t;

    typedef enum logic [2:0] {
        REG_TERMS_NEEDED   = 3'd0,
        REG_WINDOW_SIZE    = 3'd1,
        REG_REUSE_MODE     = 3'd2,
        REG_DIRECTED       = 3'd3,
        REG_USE_SUBCONTEXT = 3'd4,
        REG_USE_SEQUENCES  = 3'd5
    } reg_idx_t;

endpackage

// File: hdl/pqhm_cfg.sv
// pqhm_cfg: apb register bank holding the search configuration
// depends on pqhm_pkg
module pqhm_cfg
    import pqhm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    logic [2:0] idx;
    logic wr_en;

    assign pready = 1'b1;
    assign idx = paddr[4:2];
    assign wr_en = psel && penable && pwrite;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.terms_needed   <= 5'd1;
            cfg_reg.window_size    <= '0;
            cfg_reg.reuse_mode     <= 1'b0;
            cfg_reg.directed       <= 1'b0;
            cfg_reg.use_subcontext <= 1'b0;
            cfg_reg.use_sequences  <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_TERMS_NEEDED:   cfg_reg.terms_needed   <= pwdata[4:0];
                REG_WINDOW_SIZE:    cfg_reg.window_size    <= pwdata[19:0];
                REG_REUSE_MODE:     cfg_reg.reuse_mode     <= pwdata[0];
                REG_DIRECTED:       cfg_reg.directed       <= pwdata[0];
                REG_USE_SUBCONTEXT: cfg_reg.use_subcontext <= pwdata[0];
                REG_USE_SEQUENCES:  cfg_reg.use_sequences  <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_TERMS_NEEDED:   prdata = {27'd0, cfg_reg.terms_needed};
            REG_WINDOW_SIZE:    prdata = {12'd0, cfg_reg.window_size};
            REG_REUSE_MODE:     prdata = {31'd0, cfg_reg.reuse_mode};
            REG_DIRECTED:       prdata = {31'd0, cfg_reg.directed};
            REG_USE_SUBCONTEXT: prdata = {31'd0, cfg_reg.use_subcontext};
            REG_USE_SEQUENCES:  prdata = {31'd0, cfg_reg.use_sequences};
            default:            prdata = '0;
        endcase
    end

endmodule

// File: hdl/pqhm_engine.sv
// pqhm_engine: token memory, hit/mark memory and the search sequencer
// depends on pqhm_pkg
module pqhm_engine
    import pqhm_pkg::*;
#(
    parameter int MAX_TOKENS = 1024
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  item_t item,
    input  cfg_t  cfg,
    input  logic  out_free,
    output logic  ready,
    output res_t  res
);

    localparam int IDX_W = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int CNT_W = $clog2(MAX_TOKENS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TOKENS);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CLR, S_AT_RD, S_AT_EV, S_SC_RD, S_SC_EV,
        S_SQ_RD, S_SQ_EV, S_END, S_AS_RD, S_AS_EV, S_DONE
    } state_t;

    tok_t     tok_mem [MAX_TOKENS];
    hit_ent_t hit_mem [MAX_TOKENS];

    state_t state_reg;
    logic [CNT_W-1:0] count_reg, n_reg, last_n_reg, i_reg, w_reg, si_reg, hi_reg;
    logic [TERM_KEYS-1:0] seen_reg;
    logic [SEEN_CNT_W-1:0] cnt_reg;
    logic [15:0] hitcnt_reg;
    logic fresh_reg, strict_reg, rd_ok_reg;
    tok_t s_reg;
    logic [19:0] lag_pos_reg;
    logic [7:0] lag_seq_reg;
    logic [4:0] seq_term_reg;

    tok_t tq;
    hit_ent_t hq;

    logic tok_we;
    logic [IDX_W-1:0] tok_waddr, tok_raddr, hit_raddr, hit_waddr;
    logic hit_re, hit_we;
    hit_ent_t hit_wdata;

    logic full, sc_strict, sc_brk, sc_skip, sq_brk, pos_ok, seq_ok, over;
    logic [20:0] pdiff;
    logic [TERM_KEYS-1:0] seen_col;
    logic [SEEN_CNT_W-1:0] cnt_col;
    logic [CNT_W-1:0] count_after, w_inc;

    always_ff @(posedge clk)
    begin
        if (tok_we)
        begin
            tok_mem[tok_waddr] <= item.tok;
        end
        tq <= tok_mem[tok_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hit_we)
        begin
            hit_mem[hit_waddr] <= hit_wdata;
        end
        if (hit_re)
        begin
            hq <= hit_mem[hit_raddr];
        end
    end

    assign full = (SEEN_CNT_W'(cfg.terms_needed) == cnt_reg);
    assign sc_strict = !tq.rep && !cfg.reuse_mode;
    assign pdiff = {1'b0, tq.pos} - {1'b0, s_reg.pos};
    assign over = !pdiff[20] && (pdiff[19:0] > cfg.window_size);
    assign sc_brk = (tq.ctx != s_reg.ctx) || over
                    || (cfg.use_subcontext && (tq.sub != s_reg.sub));
    assign sc_skip = (sc_strict && ((hq.hit != 16'd0) || seen_reg[tq.term]))
                     || (cfg.directed && ((SEEN_CNT_W + 1)'(tq.term)
                         > (SEEN_CNT_W + 1)'(cnt_reg) + (SEEN_CNT_W + 1)'(1)));
    assign seen_col = seen_reg | (TERM_KEYS'(1) << tq.term);
    assign cnt_col = cnt_reg + (seen_reg[tq.term] ? SEEN_CNT_W'(0) : SEEN_CNT_W'(1));
    assign pos_ok = (tq.pos == lag_pos_reg) || ({1'b0, tq.pos} == {1'b0, lag_pos_reg} + 21'd1);
    assign seq_ok = ({1'b0, tq.seq} == {1'b0, lag_seq_reg} + 9'd1);
    assign sq_brk = !pos_ok || !tq.sv || !seq_ok;
    assign count_after = (count_reg < MAX_CNT) ? count_reg + 1'b1 : count_reg;
    assign w_inc = w_reg + 1'b1;

    assign ready = (state_reg == S_IDLE);
    assign res.valid = (state_reg == S_RD) && out_free;
    assign res.hit_id = rd_ok_reg ? hq.hit : 16'd0;

    always_comb
    begin
        tok_we = (state_reg == S_IDLE) && in_valid && !item.op && (count_reg < MAX_CNT);
        tok_waddr = count_reg[IDX_W-1:0];
        unique case (state_reg)
            S_AT_RD: tok_raddr = i_reg[IDX_W-1:0];
            S_SQ_RD: tok_raddr = si_reg[IDX_W-1:0];
            default: tok_raddr = w_reg[IDX_W-1:0];
        endcase
        hit_re = 1'b0;
        hit_raddr = w_reg[IDX_W-1:0];
        hit_we = 1'b0;
        hit_waddr = w_reg[IDX_W-1:0];
        hit_wdata = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                hit_re = in_valid && item.op;
                hit_raddr = IDX_W'(item.read_index);
            end
            S_SC_RD, S_AS_RD:
            begin
                hit_re = 1'b1;
            end
            S_SQ_RD:
            begin
                hit_re = 1'b1;
                hit_raddr = si_reg[IDX_W-1:0];
            end
            S_CLR:
            begin
                hit_we = 1'b1;
            end
            S_SC_EV:
            begin
                hit_we = !sc_brk && !sc_skip;
                hit_wdata = '{mark: 1'b1, hit: hq.hit};
            end
            S_SQ_EV:
            begin
                hit_we = !sq_brk && (tq.term == seq_term_reg);
                hit_waddr = si_reg[IDX_W-1:0];
                hit_wdata = '{mark: 1'b1, hit: hq.hit};
            end
            S_AS_EV:
            begin
                hit_we = hq.mark;
                hit_wdata = '{mark: 1'b0, hit: full ? hitcnt_reg : hq.hit};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            n_reg <= '0;
            last_n_reg <= '0;
            i_reg <= '0;
            w_reg <= '0;
            si_reg <= '0;
            hi_reg <= '0;
            seen_reg <= '0;
            cnt_reg <= '0;
            hitcnt_reg <= 16'd1;
            fresh_reg <= 1'b0;
            strict_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
            s_reg <= '0;
            lag_pos_reg <= '0;
            lag_seq_reg <= '0;
            seq_term_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (item.op)
                        begin
                            rd_ok_reg <= (32'(item.read_index) < 32'(last_n_reg));
                            state_reg <= S_RD;
                        end
                        else if (item.last)
                        begin
                            n_reg <= count_after;
                            last_n_reg <= count_after;
                            count_reg <= '0;
                            w_reg <= '0;
                            state_reg <= S_CLR;
                        end
                        else
                        begin
                            count_reg <= count_after;
                        end
                    end
                end
                S_RD:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_CLR:
                begin
                    if (w_reg == n_reg - 1'b1)
                    begin
                        i_reg <= '0;
                        seen_reg <= '0;
                        cnt_reg <= '0;
                        fresh_reg <= 1'b0;
                        hitcnt_reg <= 16'd1;
                        state_reg <= S_AT_RD;
                    end
                    else
                    begin
                        w_reg <= w_inc;
                    end
                end
                S_AT_RD:
                begin
                    state_reg <= S_AT_EV;
                end
                S_AT_EV:
                begin
                    s_reg <= tq;
                    w_reg <= i_reg;
                    hi_reg <= i_reg;
                    state_reg <= S_SC_RD;
                end
                S_SC_RD:
                begin
                    state_reg <= (w_reg == n_reg) ? S_END : S_SC_EV;
                end
                S_SC_EV:
                begin
                    if (sc_brk)
                    begin
                        state_reg <= S_END;
                    end
                    else if (sc_skip)
                    begin
                        w_reg <= w_inc;
                        state_reg <= S_SC_RD;
                    end
                    else
                    begin
                        seen_reg <= seen_col;
                        cnt_reg <= cnt_col;
                        strict_reg <= sc_strict;
                        if (w_reg > hi_reg)
                        begin
                            hi_reg <= w_reg;
                        end
                        if (cfg.use_sequences && tq.sv)
                        begin
                            si_reg <= w_inc;
                            lag_pos_reg <= tq.pos;
                            lag_seq_reg <= tq.seq;
                            seq_term_reg <= tq.term;
                            state_reg <= S_SQ_RD;
                        end
                        else if (sc_strict && (cnt_col == SEEN_CNT_W'(cfg.terms_needed)))
                        begin
                            state_reg <= S_END;
                        end
                        else
                        begin
                            w_reg <= w_inc;
                            state_reg <= S_SC_RD;
                        end
                    end
                end
                S_SQ_RD:
                begin
                    if (si_reg != n_reg)
                    begin
                        state_reg <= S_SQ_EV;
                    end
                    else if (strict_reg && full)
                    begin
                        state_reg <= S_END;
                    end
                    else
                    begin
                        w_reg <= w_inc;
                        state_reg <= S_SC_RD;
                    end
                end
                S_SQ_EV:
                begin
                    if (sq_brk)
                    begin
                        if (strict_reg && full)
                        begin
                            state_reg <= S_END;
                        end
                        else
                        begin
                            w_reg <= w_inc;
                            state_reg <= S_SC_RD;
                        end
                    end
                    else
                    begin
                        if (tq.term == seq_term_reg)
                        begin
                            seen_reg <= seen_col;
                            cnt_reg <= cnt_col;
                            lag_pos_reg <= tq.pos;
                            lag_seq_reg <= tq.seq;
                            if (si_reg > hi_reg)
                            begin
                                hi_reg <= si_reg;
                            end
                        end
                        si_reg <= si_reg + 1'b1;
                        state_reg <= S_SQ_RD;
                    end
                end
                S_END:
                begin
                    w_reg <= i_reg;
                    state_reg <= S_AS_RD;
                end
                S_AS_RD:
                begin
                    state_reg <= S_AS_EV;
                end
                S_AS_EV:
                begin
                    if (hq.mark && full && (hq.hit == 16'd0))
                    begin
                        fresh_reg <= 1'b1;
                    end
                    if (w_reg == hi_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        w_reg <= w_inc;
                        state_reg <= S_AS_RD;
                    end
                end
                S_DONE:
                begin
                    seen_reg <= '0;
                    cnt_reg <= '0;
                    fresh_reg <= 1'b0;
                    if (full && !cfg.reuse_mode && (hitcnt_reg != HIT_MAX))
                    begin
                        hitcnt_reg <= hitcnt_reg + 16'd1;
                    end
                    if (full && !cfg.reuse_mode && s_reg.rep && fresh_reg)
                    begin
                        state_reg <= S_AT_RD;
                    end
                    else if (i_reg + 1'b1 == n_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                        state_reg <= S_AT_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hdl/proximity_query_hit_marker_top.sv
// proximity_query_hit_marker_top: stream ports, apb registers and output register
// depends on pqhm_pkg, pqhm_cfg and pqhm_engine
//
// words come in on the s_ group; s_tuser is the op (0 load, 1 read)
// a load writes the token memory while it has room; loads can follow back to back
// s_tlast on a load starts the search; s_tready is low until it finishes
// the search first clears n hit entries, then for every start token runs attempts that scan
// the batch, walk sequences and then update the marked span in the hit memory
// a read's hit id enters the output register from the S_RD state once that register is free,
// and the engine then returns to idle for the next word; the hit id is 0 for tokens not in
// the last search
// the output register holds a word while m_tready is low; loads are still taken then,
// a further read is taken and waits in the engine, with s_tready low, until it frees
// reset clears the registers, counters and fill counts; no memory clearing pass is run
// configuration must be written over apb while the block is idle; it is not enforced
module proximity_query_hit_marker_top
    import pqhm_pkg::*;
#(
    parameter int MAX_TOKENS = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [79:0]           s_tdata,  // context_id, subcontext_id, position, term_index,
                                            // seq_valid, seq_index, replaceable, read_index
    input  logic                  s_tuser,  // op
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,  // hit_id
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t  cfg;
    item_t item;
    res_t  res;
    logic  accept, out_free;
    logic  m_valid_reg;
    logic [15:0] m_data_reg;

    assign item.op = s_tuser;
    assign item.last = s_tlast;
    assign item.tok.ctx = s_tdata[15:0];
    assign item.tok.sub = s_tdata[31:16];
    assign item.tok.pos = s_tdata[51:32];
    assign item.tok.term = s_tdata[56:52];
    assign item.tok.sv = s_tdata[57];
    assign item.tok.seq = s_tdata[65:58];
    assign item.tok.rep = s_tdata[66];
    assign item.read_index = s_tdata[76:67];

    assign accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

    pqhm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pqhm_engine #(
        .MAX_TOKENS (MAX_TOKENS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .item     (item),
        .cfg      (cfg),
        .out_free (out_free),
        .ready    (s_tready),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            m_data_reg <= '0;
        end
        else if (res.valid)
        begin
            m_valid_reg <= 1'b1;
            m_data_reg <= res.hit_id;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> out_free)
        else $error("result produced while output register is occupied");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_tuser) |=> !res.valid)
        else $error("load produced a result");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser) |=> !s_tready)
        else $error("new word taken while a read is pending");

endmodule

// File: bench/proximity_query_hit_marker_top_test.sv
// proximity_query_hit_marker_top_test: stream and apb testbench of the hit marker
// loads token batches, runs searches and checks every hit id read back against a
// local prediction of the search; depends on pqhm_pkg and proximity_query_hit_marker_top
module proximity_query_hit_marker_top_test
    import pqhm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 1024;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [79:0]           s_tdata;  // context_id, subcontext_id, position, term_index,
                                     // seq_valid, seq_index, replaceable, read_index
    logic                  s_tuser;  // op
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;  // hit_id
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    proximity_query_hit_marker_top #(.MAX_TOKENS(DEPTH)) dut (.*);

    // search model state
    tok_t        tokens[DEPTH];
    logic [15:0] hits[DEPTH];
    bit          marks[DEPTH];
    logic [31:0] seen;
    int          batch_len;
    int          hit_num;
    cfg_t        cfg;

    logic [15:0] hit_ids_due[$];
    int          errors;
    bit          quiet;
    int          hold_left;
    int          words_sent;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    initial
    begin
        #60ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void collect(int k);
        marks[k] = 1'b1;
        seen[tokens[k].term] = 1'b1;
    endfunction

    function automatic void follow_sequence(int start, int n);
        int     lag;
        longint d;
        lag = start;
        for (int si = start + 1; si < n; si++)
        begin
            d = longint'(tokens[si].pos) - longint'(tokens[lag].pos);
            if (d > 1 || d < 0)
                break;
            if (!tokens[si].sv)
                break;
            if (int'(tokens[si].seq) != int'(tokens[lag].seq) + 1)
                break;
            if (tokens[si].term != tokens[start].term)
                continue;
            collect(si);
            lag = si;
        end
    endfunction

    function automatic void search_hits(int n);
        bit again;
        bit strict;
        bit fresh;
        for (int k = 0; k < DEPTH; k++)
        begin
            hits[k] = '0;
            marks[k] = 1'b0;
        end
        seen = '0;
        hit_num = 1;
        for (int i = 0; i < n; i++)
        begin
            do
            begin
                again = 1'b0;
                for (int w = i; w < n; w++)
                begin
                    strict = !tokens[w].rep && !cfg.reuse_mode;
                    if (tokens[w].ctx != tokens[i].ctx)
                        break;
                    if (longint'(tokens[w].pos) - longint'(tokens[i].pos)
                        > longint'(cfg.window_size))
                        break;
                    if (cfg.use_subcontext && tokens[w].sub != tokens[i].sub)
                        break;
                    if (strict && (hits[w] != 0 || seen[tokens[w].term]))
                        continue;
                    if (cfg.directed && int'(tokens[w].term) > $countones(seen) + 1)
                        continue;
                    collect(w);
                    if (cfg.use_sequences && tokens[w].sv)
                        follow_sequence(w, n);
                    if (strict && $countones(seen) == int'(cfg.terms_needed))
                        break;
                end
                if ($countones(seen) == int'(cfg.terms_needed))
                begin
                    fresh = 1'b0;
                    for (int w = 0; w < n; w++)
                    begin
                        if (!marks[w])
                            continue;
                        if (hits[w] == 0)
                            fresh = 1'b1;
                        hits[w] = 16'(hit_num);
                    end
                    if (!cfg.reuse_mode)
                    begin
                        if (hit_num < 65535)
                            hit_num++;
                        if (tokens[i].rep && fresh)
                            again = 1'b1;
                    end
                end
                for (int k = 0; k < n; k++)
                    marks[k] = 1'b0;
                seen = '0;
            end
            while (again);
        end
    endfunction

    task automatic send_word(bit op, bit last, tok_t t, logic [9:0] ridx);
        if (!quiet && $urandom_range(99) < 7)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {3'b000, ridx, t};
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
        if (op)
            hit_ids_due.push_back(hits[ridx]);
        else
        begin
            if (batch_len < DEPTH)
            begin
                tokens[batch_len] = t;
                batch_len++;
            end
            if (last)
            begin
                search_hits(batch_len);
                batch_len = 0;
            end
        end
    endtask

    task automatic load_token(tok_t t, bit last);
        send_word(1'b0, last, t, 10'($urandom));
    endtask

    task automatic read_hit(logic [9:0] idx);
        tok_t junk;
        junk = tok_t'({$urandom, $urandom});
        send_word(1'b1, 1'($urandom_range(1)), junk, idx);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (hit_ids_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic reg_write(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_TERMS_NEEDED:   cfg.terms_needed   = value[4:0];
            REG_WINDOW_SIZE:    cfg.window_size    = value[19:0];
            REG_REUSE_MODE:     cfg.reuse_mode     = value[0];
            REG_DIRECTED:       cfg.directed       = value[0];
            REG_USE_SUBCONTEXT: cfg.use_subcontext = value[0];
            REG_USE_SEQUENCES:  cfg.use_sequences  = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(int tn, int win, bit fm, bit dir, bit sub, bit sq);
        drain();
        reg_write(REG_TERMS_NEEDED, tn);
        reg_write(REG_WINDOW_SIZE, win);
        reg_write(REG_REUSE_MODE, {31'd0, fm});
        reg_write(REG_DIRECTED, {31'd0, dir});
        reg_write(REG_USE_SUBCONTEXT, {31'd0, sub});
        reg_write(REG_USE_SEQUENCES, {31'd0, sq});
    endtask

    function automatic tok_t make_tok(int c, int s, int p, int tm, bit sv, int sq, bit rp);
        tok_t t;
        t.ctx = 16'(c);
        t.sub = 16'(s);
        t.pos = 20'(p);
        t.term = 5'(tm);
        t.sv = sv;
        t.seq = 8'(sq);
        t.rep = rp;
        return t;
    endfunction

    task automatic read_batch(int n);
        for (int k = 0; k < n; k++)
            read_hit(10'(k));
        read_hit(10'($urandom_range(DEPTH - 1)));
    endtask

    task automatic test_extremes;
        set_config(2, 20'hFFFFF, 0, 0, 0, 0);
        load_token(make_tok(16'hFFFF, 16'hFFFF, 0, 0, 1, 255, 1), 0);
        load_token(make_tok(16'hFFFF, 16'hFFFF, 20'hFFFFF, 31, 1, 0, 0), 0);
        load_token(make_tok(0, 0, 20'hFFFFF, 16, 0, 0, 0), 1);
        read_batch(3);
        read_hit(10'd1023);
        // sequence walk with a stepped-over term and a no-wrap stop
        set_config(1, 4, 0, 1, 1, 1);
        load_token(make_tok(7, 3, 10, 1, 1, 254, 0), 0);
        load_token(make_tok(7, 3, 11, 2, 1, 255, 0), 0);
        load_token(make_tok(7, 3, 11, 1, 1, 255, 0), 0);
        load_token(make_tok(7, 3, 12, 1, 1, 0, 0), 0);
        load_token(make_tok(7, 4, 12, 1, 0, 1, 1), 1);
        read_batch(5);
        // reuse mode with replaceable tokens
        set_config(2, 3, 1, 0, 0, 0);
        load_token(make_tok(1, 0, 0, 1, 0, 0, 1), 0);
        load_token(make_tok(1, 0, 1, 2, 0, 0, 1), 0);
        load_token(make_tok(1, 0, 2, 1, 0, 0, 0), 1);
        read_batch(3);
    endtask

    task automatic test_store_full;
        set_config(1, 0, 0, 0, 0, 0);
        for (int k = 0; k < DEPTH + 6; k++)
            load_token(make_tok(k, 0, k, 1, 0, 0, 0), k == DEPTH + 5);
        read_hit(10'd0);
        read_hit(10'd1023);
    endtask

    task automatic test_backpressure;
        set_config(1, 10, 0, 0, 0, 0);
        for (int k = 0; k < 8; k++)
            load_token(make_tok(2, 0, k, 1, 0, 0, k[0]), k == 7);
        hold_left = 400;
        for (int k = 0; k < 40; k++)
            read_hit(10'(k % 8));
        drain();
    endtask

    task automatic random_batch;
        int   n;
        int   c;
        int   s;
        int   p;
        int   sq;
        bit   sv;
        int   tm;
        tok_t t;
        n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        c = ($urandom_range(3) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(3);
        s = $urandom_range(16'hFFFF);
        p = ($urandom_range(4) == 0) ? $urandom_range(20'hFFFFF) : $urandom_range(50);
        sq = $urandom_range(255);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(7) == 0)
                c = c + 1;
            if ($urandom_range(5) == 0)
                s = $urandom_range(16'hFFFF);
            p = (p + $urandom_range(3)) & 20'hFFFFF;
            sv = 1'($urandom_range(1));
            sq = ($urandom_range(4) == 0) ? $urandom_range(255) : ((sq + 1) & 8'hFF);
            if ($urandom_range(9) == 0)
                tm = $urandom_range(31);
            else
                tm = $urandom_range(1, (cfg.terms_needed == 0) ? 1 : int'(cfg.terms_needed));
            t = make_tok(c & 16'hFFFF, s, p, tm, sv, sq, $urandom_range(9) < 3);
            load_token(t, k == n - 1);
            if ($urandom_range(19) == 0)
                read_hit(10'($urandom_range(DEPTH - 1)));
        end
        read_batch(n);
    endtask

    task automatic test_random;
        int tn;
        int win;
        int phase;
        phase = 0;
        while (words_sent < 1500 || phase < 4)
        begin
            case (phase % 4)
                0: tn = 16;
                1: tn = 1;
                default: tn = $urandom_range(1, 4);
            endcase
            win = (phase % 5 == 0) ? 20'hFFFFF : $urandom_range(0, 12);
            set_config(tn, win, 1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
            quiet = (phase == 3);
            for (int b = 0; b < 6; b++)
                random_batch();
            quiet = 1'b0;
            phase++;
        end
    endtask

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (hit_ids_due.size() == 0)
            begin
                $display("%0t: hit_id with nothing expected, actual %0d", $realtime, m_tdata);
                errors++;
            end
            else
            begin
                if (m_tdata !== hit_ids_due[0])
                begin
                    $display("%0t: hit_id expected %0d actual %0d",
                             $realtime, hit_ids_due[0], m_tdata);
                    errors++;
                end
                void'(hit_ids_due.pop_front());
            end
        end
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= quiet || ($urandom_range(99) >= 7);
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        quiet = 1'b0;
        hold_left = 0;
        words_sent = 0;
        batch_len = 0;
        hit_num = 1;
        seen = '0;
        cfg = '{terms_needed: 5'd1, window_size: '0, reuse_mode: 1'b0,
                directed: 1'b0, use_subcontext: 1'b0, use_sequences: 1'b0};
        for (int k = 0; k < DEPTH; k++)
        begin
            hits[k] = '0;
            marks[k] = 1'b0;
            tokens[k] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_store_full();
        test_backpressure();
        test_random();
        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
